// ===== rtl/qslerp_pkg.sv =====
package qslerp_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int WF           = 30;          // working fraction bits

  localparam int CMP_W  = 16;                // quaternion component
  localparam int T_W    = 15;                // blend input
  localparam int TOL_W  = 11;                // tolerance register
  localparam int PROD_W = 2 * CMP_W;         // component product
  localparam int DOT_W  = PROD_W + 2;        // sum of four products
  localparam int DD_W   = WF + 1;            // |d|, up to 1.0
  localparam int D_W    = WF + 2;            // signed d
  localparam int RAD_W  = 2 * WF + 1;        // radicand 1 - d*d
  localparam int SQ_W   = WF + 1;            // root
  localparam int ISQRT_LAT = (RAD_W + 1) / 2;
  localparam int ANG_W  = 32;                // angle, unsigned, [0, pi]
  localparam int CW     = 34;                // cordic x/y
  localparam int ZW     = 35;                // cordic z
  localparam int NUM_W  = 48;                // blend numerator
  localparam int QB     = CMP_W + 1;         // quotient bits
  localparam int DIV_LAT = QB;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2);
  localparam logic [ANG_W-1:0] HALF_PI_W = 32'd1686629713;
  localparam logic [ANG_W-1:0] PI_W      = 32'd3373259426;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef logic signed [CMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t [3:0]    a;
    comp_t [3:0]    b;
    logic [T_W-1:0] t;
    logic           same;
  } side_t;

  typedef struct packed {
    side_t sd;
    logic  below_tol;
  } sin_side_t;

  typedef struct packed {
    comp_t [3:0] a;
    logic        byp;
  } tail_t;

  typedef struct packed {
    comp_t [3:0] a;
    logic        byp;
    logic [3:0]  neg;
    logic [3:0]  ovf;
  } div_side_t;

endpackage

// ===== rtl/qslerp_isqrt.sv =====
// Floor square root, one result bit per stage.
module qslerp_isqrt
  import qslerp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [RAD_W-1:0] rad,
  output logic [SQ_W-1:0]  root
);

  logic [RAD_W-1:0] n_r   [ISQRT_LAT];
  logic [RAD_W-1:0] q_r   [ISQRT_LAT];
  logic [RAD_W-1:0] n_src [ISQRT_LAT];
  logic [RAD_W-1:0] q_src [ISQRT_LAT];
  logic [RAD_W-1:0] n_nxt [ISQRT_LAT];
  logic [RAD_W-1:0] q_nxt [ISQRT_LAT];

  always_comb begin
    logic [RAD_W-1:0] bitv;
    logic [RAD_W:0]   trial;
    n_src[0] = rad;
    q_src[0] = '0;
    for (int i = 1; i < ISQRT_LAT; i++) begin
      n_src[i] = n_r[i-1];
      q_src[i] = q_r[i-1];
    end
    for (int i = 0; i < ISQRT_LAT; i++) begin
      bitv  = RAD_W'(1) << (RAD_W - 1 - 2 * i);
      trial = {1'b0, q_src[i]} + {1'b0, bitv};
      if ({1'b0, n_src[i]} >= trial) begin
        n_nxt[i] = n_src[i] - trial[RAD_W-1:0];
        q_nxt[i] = (q_src[i] >> 1) + bitv;
      end else begin
        n_nxt[i] = n_src[i];
        q_nxt[i] = q_src[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ISQRT_LAT; i++) begin
        n_r[i] <= n_nxt[i];
        q_r[i] <= q_nxt[i];
      end
    end
  end

  assign root = q_r[ISQRT_LAT-1][SQ_W-1:0];

endmodule

// ===== rtl/qslerp_acos.sv =====
// Vectoring CORDIC on (d, sqrt(1-d*d)); angle clamped to [0, pi].
module qslerp_acos
  import qslerp_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [D_W-1:0] d,
  input  logic [SQ_W-1:0]       s,
  output logic [ANG_W-1:0]      theta
);

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic signed [CW-1:0] x_src [CORDIC_STEPS];
  logic signed [CW-1:0] y_src [CORDIC_STEPS];
  logic signed [ZW-1:0] z_src [CORDIC_STEPS];
  logic signed [CW-1:0] x_nxt [CORDIC_STEPS];
  logic signed [CW-1:0] y_nxt [CORDIC_STEPS];
  logic signed [ZW-1:0] z_nxt [CORDIC_STEPS];

  always_comb begin
    logic signed [ZW-1:0] at;
    if (d < 0) begin
      x_src[0] = CW'(signed'({1'b0, s}));
      y_src[0] = -CW'(d);
      z_src[0] = $signed(ZW'(HALF_PI_W));
    end else begin
      x_src[0] = CW'(d);
      y_src[0] = CW'(signed'({1'b0, s}));
      z_src[0] = '0;
    end
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      x_src[i] = x_r[i-1];
      y_src[i] = y_r[i-1];
      z_src[i] = z_r[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      at = $signed(ZW'(ATAN_TAB[i]));
      if (y_src[i] > 0) begin
        x_nxt[i] = x_src[i] + (y_src[i] >>> i);
        y_nxt[i] = y_src[i] - (x_src[i] >>> i);
        z_nxt[i] = z_src[i] + at;
      end else begin
        x_nxt[i] = x_src[i] - (y_src[i] >>> i);
        y_nxt[i] = y_src[i] + (x_src[i] >>> i);
        z_nxt[i] = z_src[i] - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  always_comb begin
    if (z_r[CORDIC_STEPS-1] < 0) begin
      theta = '0;
    end else if (z_r[CORDIC_STEPS-1] > $signed(ZW'(PI_W))) begin
      theta = PI_W;
    end else begin
      theta = z_r[CORDIC_STEPS-1][ANG_W-1:0];
    end
  end

endmodule

// ===== rtl/qslerp_sin.sv =====
// Rotation CORDIC sine, gain left in; input folded into [0, pi/2].
module qslerp_sin
  import qslerp_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANG_W-1:0]      ang,
  output logic signed [CW-1:0]  sine
);

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic signed [CW-1:0] x_src [CORDIC_STEPS];
  logic signed [CW-1:0] y_src [CORDIC_STEPS];
  logic signed [ZW-1:0] z_src [CORDIC_STEPS];
  logic signed [CW-1:0] x_nxt [CORDIC_STEPS];
  logic signed [CW-1:0] y_nxt [CORDIC_STEPS];
  logic signed [ZW-1:0] z_nxt [CORDIC_STEPS];

  always_comb begin
    logic [ANG_W-1:0]     af;
    logic signed [ZW-1:0] at;
    af = (ang > HALF_PI_W) ? PI_W - ang : ang;
    x_src[0] = CW'(1) <<< (WF - 1);
    y_src[0] = '0;
    z_src[0] = $signed(ZW'(af));
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      x_src[i] = x_r[i-1];
      y_src[i] = y_r[i-1];
      z_src[i] = z_r[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      at = $signed(ZW'(ATAN_TAB[i]));
      if (z_src[i] >= 0) begin
        x_nxt[i] = x_src[i] - (y_src[i] >>> i);
        y_nxt[i] = y_src[i] + (x_src[i] >>> i);
        z_nxt[i] = z_src[i] - at;
      end else begin
        x_nxt[i] = x_src[i] + (y_src[i] >>> i);
        y_nxt[i] = y_src[i] - (x_src[i] >>> i);
        z_nxt[i] = z_src[i] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign sine = y_r[CORDIC_STEPS-1];

endmodule

// ===== rtl/qslerp_div.sv =====
// Restoring divider, one quotient bit per stage. Caller guarantees num < den << QB.
module qslerp_div
  import qslerp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [SQ_W-1:0]  den,
  output logic [QB-1:0]    quo
);

  logic [NUM_W-1:0] rem_r [DIV_LAT];
  logic [SQ_W-1:0]  den_r [DIV_LAT];
  logic [QB-1:0]    q_r   [DIV_LAT];
  logic [NUM_W-1:0] rem_src [DIV_LAT];
  logic [SQ_W-1:0]  den_src [DIV_LAT];
  logic [QB-1:0]    q_src   [DIV_LAT];
  logic [NUM_W-1:0] rem_nxt [DIV_LAT];
  logic [QB-1:0]    q_nxt   [DIV_LAT];

  always_comb begin
    logic [NUM_W-1:0] dsh;
    rem_src[0] = num;
    den_src[0] = den;
    q_src[0]   = '0;
    for (int i = 1; i < DIV_LAT; i++) begin
      rem_src[i] = rem_r[i-1];
      den_src[i] = den_r[i-1];
      q_src[i]   = q_r[i-1];
    end
    for (int i = 0; i < DIV_LAT; i++) begin
      dsh = NUM_W'(den_src[i]) << (QB - 1 - i);
      if (rem_src[i] >= dsh) begin
        rem_nxt[i] = rem_src[i] - dsh;
        q_nxt[i]   = {q_src[i][QB-2:0], 1'b1};
      end else begin
        rem_nxt[i] = rem_src[i];
        q_nxt[i]   = {q_src[i][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_src[i];
        q_r[i]   <= q_nxt[i];
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule

// ===== rtl/quaternion_slerp.sv =====
// Quaternion slerp: out = (sin((1-t)th)*A + sin(t*th)*B) / sin(th), th = acos(A.B) with the dot
// clamped to [-1,1], Q2.14 in and out, blend t in Q.14 saturated at 1.0. A passes through when
// A and B are bit-equal, when th is below cfg angle_tolerance (Q.14 rad, reset 2), or when
// sin(th) comes out non-positive. No shortest-arc flip is done. Results are rounded half away
// from zero and saturated to 16 bits. One word is accepted every cycle while the output is
// not stalled; each word passes from acceptance to the output register through the 31-stage
// square root, the two 16-stage CORDIC pipes (acos, then three sines side by side) and the
// 17-stage divider. A stall on the output freezes the whole pipe; no word is lost or repeated.
module quaternion_slerp
  import qslerp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  comp_t             in_first_w,
  input  comp_t             in_first_x,
  input  comp_t             in_first_y,
  input  comp_t             in_first_z,
  input  comp_t             in_second_w,
  input  comp_t             in_second_x,
  input  comp_t             in_second_y,
  input  comp_t             in_second_z,
  input  logic [T_W-1:0]    in_blend,
  output logic              out_valid,
  input  logic              out_stall,
  output comp_t             out_w,
  output comp_t             out_x,
  output comp_t             out_y,
  output comp_t             out_z,
  input  logic              cfg_we,
  input  logic [TOL_W-1:0]  cfg_data
);

  // total register stages from input to output register
  localparam int LAT = 4 + ISQRT_LAT + CORDIC_STEPS + 3 + CORDIC_STEPS + 3 + DIV_LAT + 1;

  logic             adv;
  logic [LAT-1:0]   vld_r;
  logic [TOL_W-1:0] tol_r;

  // whole pipe moves unless the output word is held
  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  // ---- S1: component products, equality
  side_t                    side_in;
  side_t                    side1_r, side2_r, side3_r, side4_r;
  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [D_W-1:0]    d3_r, d4_r;
  logic [DD_W-1:0]          dd3_r;
  logic [RAD_W-1:0]         rad4_r;

  always_comb begin
    side_in.a    = {in_first_z, in_first_y, in_first_x, in_first_w};
    side_in.b    = {in_second_z, in_second_y, in_second_x, in_second_w};
    side_in.t    = in_blend;
    side_in.same = (in_first_w == in_second_w) && (in_first_x == in_second_x) &&
                   (in_first_y == in_second_y) && (in_first_z == in_second_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= side_in;
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= $signed(side_in.a[k]) * $signed(side_in.b[k]);
      end
    end
  end

  // ---- S2: dot sum
  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= side1_r;
      dot_r   <= DOT_W'(prod_r[0]) + DOT_W'(prod_r[1]) + DOT_W'(prod_r[2]) +
                 DOT_W'(prod_r[3]);
    end
  end

  // ---- S3: clamp to |1| and move to working fraction
  logic                   dneg;
  logic [DOT_W-1:0]       dmag;
  logic [2*FRAC_BITS:0]   dclamp;
  logic [DD_W-1:0]        dd_nxt;

  always_comb begin
    dneg = dot_r < 0;
    dmag = dneg ? DOT_W'(-dot_r) : DOT_W'(dot_r);
    if (dmag > (DOT_W'(1) << (2 * FRAC_BITS))) begin
      dclamp = (2 * FRAC_BITS + 1)'(1) << (2 * FRAC_BITS);
    end else begin
      dclamp = dmag[2*FRAC_BITS:0];
    end
    dd_nxt = DD_W'(dclamp) << (WF - 2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r <= side2_r;
      dd3_r   <= dd_nxt;
      d3_r    <= dneg ? -$signed(D_W'(dd_nxt)) : $signed(D_W'(dd_nxt));
    end
  end

  // ---- S4: radicand 1 - d*d
  logic [2*DD_W-1:0] ddsq;
  assign ddsq = dd3_r * dd3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r <= side3_r;
      d4_r    <= d3_r;
      rad4_r  <= (RAD_W'(1) << (2 * WF)) - ddsq[RAD_W-1:0];
    end
  end

  // ---- square root, side data alongside
  logic [SQ_W-1:0]       root;
  side_t                 sq_side_r [ISQRT_LAT];
  logic signed [D_W-1:0] sq_d_r    [ISQRT_LAT];

  qslerp_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad4_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= side4_r;
      sq_d_r[0]    <= d4_r;
      for (int i = 1; i < ISQRT_LAT; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
        sq_d_r[i]    <= sq_d_r[i-1];
      end
    end
  end

  // ---- acos
  logic [ANG_W-1:0] theta;
  side_t            ac_side_r [CORDIC_STEPS];

  qslerp_acos u_acos (
    .clk   (clk),
    .en    (adv),
    .d     (sq_d_r[ISQRT_LAT-1]),
    .s     (root),
    .theta (theta)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ac_side_r[0] <= sq_side_r[ISQRT_LAT-1];
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        ac_side_r[i] <= ac_side_r[i-1];
      end
    end
  end

  // ---- T1: register angle
  side_t            t1_side_r, t2_side_r, t3_side_r;
  logic [ANG_W-1:0] th1_r, th2_r, th3_r, a2_r, arg2_r, arg1_r;
  logic             small2_r, small3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_side_r <= ac_side_r[CORDIC_STEPS-1];
      th1_r     <= theta;
    end
  end

  // ---- T2: tolerance test, t*theta
  logic [T_W-1:0]        tsat;
  logic [WF:0]           tw;
  logic [WF+ANG_W:0]     tth;

  always_comb begin
    tsat = (t1_side_r.t > (T_W'(1) << FRAC_BITS)) ? (T_W'(1) << FRAC_BITS) : t1_side_r.t;
    tw   = (WF + 1)'(tsat) << (WF - FRAC_BITS);
    tth  = tw * th1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_side_r <= t1_side_r;
      th2_r     <= th1_r;
      a2_r      <= tth[WF+ANG_W-1:WF];
      small2_r  <= th1_r < (ANG_W'(tol_r) << (WF - FRAC_BITS));
    end
  end

  // ---- T3: sine arguments
  always_ff @(posedge clk) begin
    if (adv) begin
      t3_side_r <= t2_side_r;
      small3_r  <= small2_r;
      th3_r     <= th2_r;
      arg2_r    <= a2_r;
      arg1_r    <= th2_r - a2_r;
    end
  end

  // ---- three sines in parallel
  logic signed [CW-1:0] ws, w1, w2;
  sin_side_t            sn_side_r [CORDIC_STEPS];

  qslerp_sin u_sin_th (.clk(clk), .en(adv), .ang(th3_r),  .sine(ws));
  qslerp_sin u_sin_w1 (.clk(clk), .en(adv), .ang(arg1_r), .sine(w1));
  qslerp_sin u_sin_w2 (.clk(clk), .en(adv), .ang(arg2_r), .sine(w2));

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_side_r[0] <= '{sd: t3_side_r, below_tol: small3_r};
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        sn_side_r[i] <= sn_side_r[i-1];
      end
    end
  end

  // ---- T4: weight products
  sin_side_t                   sn_last;
  logic signed [CW+CMP_W-1:0]  pfa [4];
  logic signed [CW+CMP_W-1:0]  pfb [4];
  logic signed [NUM_W-1:0]     pa_r [4];
  logic signed [NUM_W-1:0]     pb_r [4];
  logic signed [NUM_W-1:0]     num_r [4];
  tail_t                       t4_r, t5_r;
  logic [SQ_W-1:0]             den4_r, den5_r;

  assign sn_last = sn_side_r[CORDIC_STEPS-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pfa[k] = w1 * $signed(sn_last.sd.a[k]);
      pfb[k] = w2 * $signed(sn_last.sd.b[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_r.a   <= sn_last.sd.a;
      t4_r.byp <= sn_last.sd.same || sn_last.below_tol || (ws <= 0);
      den4_r   <= ws[SQ_W-1:0];
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= pfa[k][NUM_W-1:0];
        pb_r[k] <= pfb[k][NUM_W-1:0];
      end
    end
  end

  // ---- T5: numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      t5_r   <= t4_r;
      den5_r <= den4_r;
      for (int k = 0; k < 4; k++) begin
        num_r[k] <= pa_r[k] + pb_r[k];
      end
    end
  end

  // ---- T6: magnitude plus half divisor, overflow precheck
  logic [NUM_W-1:0] nabs [4];
  logic [NUM_W-1:0] nmag [4];
  logic [NUM_W-1:0] nmag_r [4];
  logic [3:0]       ovf_nxt;
  logic [3:0]       neg_nxt;
  div_side_t        t6_r;
  logic [SQ_W-1:0]  den6_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg_nxt[k] = num_r[k] < 0;
      nabs[k]    = neg_nxt[k] ? NUM_W'(-num_r[k]) : NUM_W'(num_r[k]);
      nmag[k]    = nabs[k] + NUM_W'(den5_r >> 1);
      ovf_nxt[k] = (nmag[k] >> QB) >= NUM_W'(den5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t6_r.a   <= t5_r.a;
      t6_r.byp <= t5_r.byp;
      t6_r.neg <= neg_nxt;
      t6_r.ovf <= ovf_nxt;
      den6_r   <= den5_r;
      for (int k = 0; k < 4; k++) begin
        nmag_r[k] <= nmag[k];
      end
    end
  end

  // ---- dividers, one per component
  logic [QB-1:0] quo [4];
  div_side_t     dv_side_r [DIV_LAT];

  for (genvar k = 0; k < 4; k++) begin : g_div
    qslerp_div u_div (
      .clk (clk),
      .en  (adv),
      .num (nmag_r[k]),
      .den (den6_r),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= t6_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // ---- output register: saturate, or pass A through
  div_side_t   dv_last;
  comp_t [3:0] res_nxt;
  comp_t [3:0] res_r;

  assign dv_last = dv_side_r[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dv_last.byp) begin
        res_nxt[k] = dv_last.a[k];
      end else if (!dv_last.neg[k]) begin
        if (dv_last.ovf[k] || (quo[k] > QB'(16'h7FFF))) begin
          res_nxt[k] = 16'sh7FFF;
        end else begin
          res_nxt[k] = quo[k][CMP_W-1:0];
        end
      end else begin
        if (dv_last.ovf[k] || (quo[k] > QB'(17'h08000))) begin
          res_nxt[k] = 16'sh8000;
        end else begin
          res_nxt[k] = -quo[k][CMP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_w = res_r[0];
  assign out_x = res_r[1];
  assign out_y = res_r[2];
  assign out_z = res_r[3];

endmodule

// ===== tb/slerp_checker.sv =====
`timescale 1ns / 1ps

module slerp_checker
  import qslerp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  comp_t            in_first_w,
  input  comp_t            in_first_x,
  input  comp_t            in_first_y,
  input  comp_t            in_first_z,
  input  comp_t            in_second_w,
  input  comp_t            in_second_x,
  input  comp_t            in_second_y,
  input  comp_t            in_second_z,
  input  logic [T_W-1:0]   in_blend,
  input  logic             out_valid,
  input  logic             out_stall,
  input  comp_t            out_w,
  input  comp_t            out_x,
  input  comp_t            out_y,
  input  comp_t            out_z,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef comp_t quat_t [4];

  // atan(2^-i) with 30 fraction bits
  localparam longint ATAN_W [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };
  localparam longint ONE_30  = 64'd1 << 30;
  localparam longint HPI     = 64'd1686629713;
  localparam longint PI30    = 64'd3373259426;

  logic [TOL_W-1:0] tol_shadow;
  comp_t exp_w[$], exp_x[$], exp_y[$], exp_z[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint acos_vec(longint d);
    longint ad, s, x, y, z, nx;
    ad = (d < 0) ? -d : d;
    s = int_sqrt((64'd1 << 60) - ad * ad);
    if (d < 0) begin
      x = s; y = -d; z = HPI;
    end else begin
      x = d; y = s; z = 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z = z + ATAN_W[i];
      end else begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z = z - ATAN_W[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > PI30) z = PI30;
    return z;
  endfunction

  // sine scaled by CORDIC gain
  function automatic longint scaled_sin(longint a);
    longint x, y, z, nx;
    x = ONE_30 >> 1;
    y = 0;
    if (a > HPI) a = PI30 - a;
    z = a;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z = z - ATAN_W[i];
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z = z + ATAN_W[i];
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic comp_t round_div(longint num, longint den);
    longint q;
    if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return comp_t'(q);
  endfunction

  function automatic quat_t slerp_predict(quat_t qa, quat_t qb, logic [T_W-1:0] tb_in,
                                          logic [TOL_W-1:0] tol);
    quat_t res;
    longint dot, mag, d, theta, s, w1, w2, a2, t;
    bit same;
    same = 1;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      if (qa[k] != qb[k]) same = 0;
      dot = dot + longint'(qa[k]) * longint'(qb[k]);
      res[k] = qa[k];
    end
    if (same) return res;
    mag = (dot < 0) ? -dot : dot;
    if (mag > (64'd1 << 28)) mag = 64'd1 << 28;
    mag = mag << 2;
    d = (dot < 0) ? -mag : mag;
    theta = acos_vec(d);
    if (theta < (longint'(tol) << 16)) return res;
    s = scaled_sin(theta);
    if (s <= 0) return res;
    t = tb_in;
    if (t > 16384) t = 16384;
    t = t << 16;
    a2 = (t * theta) >>> 30;  // t*theta < 2^62, fits
    w2 = scaled_sin(a2);
    w1 = scaled_sin(theta - a2);
    for (int k = 0; k < 4; k++)
      res[k] = round_div(w1 * longint'(qa[k]) + w2 * longint'(qb[k]), s);
    return res;
  endfunction

  assign pending = exp_w.size();

  always @(posedge clk) begin
    quat_t qa, qb, r;
    if (!rst_n) begin
      tol_shadow <= TOL_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_we) tol_shadow <= cfg_data;
      if (in_valid && !in_stall) begin
        qa = '{in_first_w, in_first_x, in_first_y, in_first_z};
        qb = '{in_second_w, in_second_x, in_second_y, in_second_z};
        r = slerp_predict(qa, qb, in_blend, tol_shadow);
        exp_w.push_back(r[0]);
        exp_x.push_back(r[1]);
        exp_y.push_back(r[2]);
        exp_z.push_back(r[3]);
      end
      if (out_valid && !out_stall) begin
        if (exp_w.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word %0d %0d %0d %0d",
                                        out_w, out_x, out_y, out_z);
          fail_count <= fail_count + 1;
        end else begin
          if (out_w !== exp_w[0] || out_x !== exp_x[0] || out_y !== exp_y[0] ||
              out_z !== exp_z[0]) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       exp_w[0], exp_x[0], exp_y[0], exp_z[0], out_w, out_x, out_y, out_z);
            fail_count <= fail_count + 1;
          end
          void'(exp_w.pop_front());
          void'(exp_x.pop_front());
          void'(exp_y.pop_front());
          void'(exp_z.pop_front());
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import qslerp_pkg::*;

  localparam int PIPE_LAT = 91;  // acceptance to output register

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  comp_t fw = 0, fx = 0, fy = 0, fz = 0, sw = 0, sx = 0, sy = 0, sz = 0;
  logic [T_W-1:0] blend = 0;
  logic out_valid;
  logic out_stall = 0;
  comp_t out_w, out_x, out_y, out_z;
  logic cfg_we = 0;
  logic [TOL_W-1:0] cfg_data = 0;
  int fail_count, pending;
  bit idle_free = 0;  // quiet stretch: no gaps on either side
  logic [TOL_W-1:0] tol_set [4] = '{11'd0, 11'd1024, 11'd2047, 11'd300};

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  quaternion_slerp u_top (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_w(fw), .in_first_x(fx), .in_first_y(fy), .in_first_z(fz),
    .in_second_w(sw), .in_second_x(sx), .in_second_y(sy), .in_second_z(sz),
    .in_blend(blend), .out_valid, .out_stall, .out_w, .out_x, .out_y, .out_z,
    .cfg_we, .cfg_data
  );

  slerp_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_w(fw), .in_first_x(fx), .in_first_y(fy), .in_first_z(fz),
    .in_second_w(sw), .in_second_x(sx), .in_second_y(sy), .in_second_z(sz),
    .in_blend(blend), .out_valid, .out_stall, .out_w, .out_x, .out_y, .out_z,
    .cfg_we, .cfg_data, .fail_count, .pending
  );

  // receiver back-pressure, ~22% of cycles
  always @(posedge clk)
    out_stall <= !idle_free && ($urandom_range(99) < 22);

  // hand one word to the block; returns after it is accepted
  task automatic send_word(comp_t a0, a1, a2, a3, b0, b1, b2, b3, logic [T_W-1:0] t);
    while (!idle_free && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    fw <= a0; fx <= a1; fy <= a2; fz <= a3;
    sw <= b0; sx <= b1; sy <= b2; sz <= b3;
    blend <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_tol(logic [TOL_W-1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic comp_t rnd_comp();
    return comp_t'($urandom_range(65535));
  endfunction

  // roughly unit components, Q2.14, sign random
  function automatic comp_t unit_comp();
    int m;
    m = $urandom_range(16384);
    return comp_t'($urandom_range(1) ? -m : m);
  endfunction

  task automatic send_random();
    comp_t a[4], b[4];
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 4; k++) begin
      a[k] = (kind < 7) ? comp_t'(unit_comp() / 2) : rnd_comp();
      b[k] = (kind < 7) ? comp_t'(unit_comp() / 2) : rnd_comp();
    end
    if (kind == 7) b = a;  // equal pair
    if (kind == 8) begin   // near-equal pair, exercises tolerance
      b = a;
      b[$urandom_range(3)] += comp_t'($urandom_range(40) - 20);
    end
    send_word(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3],
              ($urandom_range(3) == 0) ? T_W'($urandom) : T_W'($urandom_range(16384)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: identity vs others, antipodal, extremes, blend saturation
    idle_free = 1;
    send_word(16384, 0, 0, 0, 16384, 0, 0, 0, 8192);          // identical
    send_word(16384, 0, 0, 0, 0, 16384, 0, 0, 0);             // t = 0
    send_word(16384, 0, 0, 0, 0, 16384, 0, 0, 16384);         // t = 1
    send_word(16384, 0, 0, 0, 0, 16384, 0, 0, 8192);          // half way
    send_word(16384, 0, 0, 0, 0, 16384, 0, 0, 32767);         // blend saturates
    send_word(16384, 0, 0, 0, -16384, 0, 0, 0, 8192);         // antipodal
    send_word(16384, 0, 0, 0, 16383, 100, 0, 0, 8192);        // tiny angle
    send_word(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 12000);
    send_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32766, 5000);
    send_word(-32768, 0, 0, 0, 0, -32768, 0, 0, 8192);
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 16384);                 // both zero, identical
    send_word(0, 0, 0, 0, 16384, 0, 0, 0, 8192);              // zero dot
    send_word(11585, 11585, 0, 0, 11585, -11585, 0, 0, 1);
    send_word(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192, 16383);
    send_word(16384, 0, 0, 0, -16383, 150, 0, 0, 4000);       // near antipodal
    idle_free = 0;
    drain();

    // tolerance sweep, extremes included; random traffic under each
    foreach (tol_set[i]) begin
      write_tol(tol_set[i]);
      send_word(16384, 0, 0, 0, 16000, 3000, 0, 0, 8192);
      send_word(16384, 0, 0, 0, 16383, 100, 0, 0, 8192);
      for (int n = 0; n < 130; n++) begin
        idle_free = (i == 1 && n >= 30 && n < 90);
        send_random();
      end
      idle_free = 0;
      drain();  // sender holds off until every result is back
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qslerp_pkg.sv
rtl/qslerp_isqrt.sv
rtl/qslerp_acos.sv
rtl/qslerp_sin.sv
rtl/qslerp_div.sv
rtl/quaternion_slerp.sv
tb/slerp_checker.sv
tb/testbench.sv
